// ===== rtl/cfdc_pkg.sv =====
// shared types, constants and crc helper for the command frame deframer
// used by every module in rtl/; depends on nothing
`default_nettype none

package cfdc_pkg;

  // framing constants
  localparam logic [7:0]  START_BYTE = 8'hAA;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_SEND_DATA = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SHUTDOWN  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STARTUP   = 2'd2;
  localparam int unsigned CFG_DATA_W = 8;

  // register reset values
  localparam logic [7:0] SEND_DATA_RESET = 8'd3;
  localparam logic [7:0] SHUTDOWN_RESET  = 8'd1;
  localparam logic [7:0] STARTUP_RESET   = 8'd2;

  // command kinds reported on the result
  localparam logic [1:0] KIND_SHUTDOWN = 2'd0;
  localparam logic [1:0] KIND_STARTUP  = 2'd1;
  localparam logic [1:0] KIND_DATA     = 2'd2;

  // result queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       line_timeout;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         command_kind;
    logic signed [15:0] shunt_current_tenths;
    logic [7:0]         staleness;
  } out_word_t;

  typedef struct packed {
    logic [7:0] send_data_code;
    logic [7:0] shutdown_code;
    logic [7:0] startup_code;
  } cfg_regs_t;

  // crc-16/modbus update by one byte, reflected, eight shift steps
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cfdc_front.sv =====
// frame parser: start byte hunt, crc accumulation, frame check and classification
// depends on cfdc_pkg; pushes finished commands into the result queue
`default_nettype none

module cfdc_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               take,
  input  wire cfdc_pkg::in_word_t word,
  input  wire cfdc_pkg::cfg_regs_t cfg,
  output logic                    push,
  output cfdc_pkg::out_word_t     push_word
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CMD    = 7'b0000010,
    ST_CUR_HI = 7'b0000100,
    ST_CUR_LO = 7'b0001000,
    ST_STALE  = 7'b0010000,
    ST_CRC_LO = 7'b0100000,
    ST_CRC_HI = 7'b1000000
  } state_t;

  state_t      state, state_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  cmd_byte;
  logic [7:0]  cur_hi, cur_lo, stale;
  logic [7:0]  crc_low;
  logic [15:0] crc_fed;
  logic        crc_ok;

  assign crc_fed = cfdc_pkg::crc_feed(crc, word.rx_byte);
  assign crc_ok  = ({word.rx_byte, crc_low} == crc);

  always_comb begin
    state_next = state;
    crc_next   = crc;
    if (take) begin
      if (word.line_timeout) begin
        state_next = ST_IDLE;
        crc_next   = cfdc_pkg::CRC_INIT;
      end else begin
        unique case (state)
          ST_CMD: begin
            crc_next   = crc_fed;
            state_next = (word.rx_byte == cfg.send_data_code) ? ST_CUR_HI : ST_CRC_LO;
          end
          ST_CUR_HI: begin
            crc_next   = crc_fed;
            state_next = ST_CUR_LO;
          end
          ST_CUR_LO: begin
            crc_next   = crc_fed;
            state_next = ST_STALE;
          end
          ST_STALE: begin
            crc_next   = crc_fed;
            state_next = ST_CRC_LO;
          end
          ST_CRC_LO: begin
            state_next = ST_CRC_HI;
          end
          ST_CRC_HI: begin
            state_next = ST_IDLE;
            crc_next   = cfdc_pkg::CRC_INIT;
          end
          default: begin
            if (word.rx_byte == cfdc_pkg::START_BYTE) begin
              state_next = ST_CMD;
              crc_next   = cfdc_pkg::CRC_INIT;
            end else begin
              state_next = ST_IDLE;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      crc   <= cfdc_pkg::CRC_INIT;
    end else begin
      state <= state_next;
      crc   <= crc_next;
    end
  end

  // frame bytes, cleared on reset since a late code change can expose them
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_byte <= '0;
      cur_hi   <= '0;
      cur_lo   <= '0;
      stale    <= '0;
      crc_low  <= '0;
    end else if (take && !word.line_timeout) begin
      if (state == ST_CMD)    cmd_byte <= word.rx_byte;
      if (state == ST_CUR_HI) cur_hi   <= word.rx_byte;
      if (state == ST_CUR_LO) cur_lo   <= word.rx_byte;
      if (state == ST_STALE)  stale    <= word.rx_byte;
      if (state == ST_CRC_LO) crc_low  <= word.rx_byte;
    end
  end

  // classification on the last crc byte, data request wins over control codes
  always_comb begin
    push      = 1'b0;
    push_word = '0;
    if (take && !word.line_timeout && state == ST_CRC_HI && crc_ok) begin
      if (cmd_byte == cfg.send_data_code) begin
        push                           = 1'b1;
        push_word.command_kind         = cfdc_pkg::KIND_DATA;
        push_word.shunt_current_tenths = {cur_hi, cur_lo};
        push_word.staleness            = stale;
      end else if (cmd_byte == cfg.shutdown_code) begin
        push                   = 1'b1;
        push_word.command_kind = cfdc_pkg::KIND_SHUTDOWN;
      end else if (cmd_byte == cfg.startup_code) begin
        push                   = 1'b1;
        push_word.command_kind = cfdc_pkg::KIND_STARTUP;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cfdc_queue.sv =====
// short result queue between the frame parser and the output stage
// depends on cfdc_pkg for depth and word type
`default_nettype none

module cfdc_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire cfdc_pkg::out_word_t push_word,
  input  wire logic                pop,
  output logic                     full,
  output logic                     nonempty,
  output cfdc_pkg::out_word_t      head
);

  cfdc_pkg::out_word_t                 slots [cfdc_pkg::QUEUE_DEPTH];
  logic [cfdc_pkg::QUEUE_PTR_W-1:0]    wr_ptr, rd_ptr;
  logic [cfdc_pkg::QUEUE_CNT_W-1:0]    count;

  localparam logic [cfdc_pkg::QUEUE_PTR_W-1:0] LAST_SLOT =
    cfdc_pkg::QUEUE_PTR_W'(cfdc_pkg::QUEUE_DEPTH - 1);
  localparam logic [cfdc_pkg::QUEUE_CNT_W-1:0] FULL_COUNT =
    cfdc_pkg::QUEUE_CNT_W'(cfdc_pkg::QUEUE_DEPTH);

  assign full     = (count == FULL_COUNT);
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cfdc_back.sv =====
// output stage: holds one result word until the consumer takes it
// depends on cfdc_pkg; pulls from the result queue
`default_nettype none

module cfdc_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_nonempty,
  input  wire cfdc_pkg::out_word_t q_head,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output cfdc_pkg::out_word_t      out_word
);

  assign pop = q_nonempty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= q_nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_word <= q_head;
  end

endmodule

`default_nettype wire

// ===== rtl/command_frame_deframer_crc16_top.sv =====
// command frame deframer with crc-16/modbus check: one received byte per cycle while
// rx_ready is high; a result word passes from the result queue into the output register
// when the output is free; rx_ready drops only while the two-entry result queue is full.
// synchronous active-high reset: parser to start-byte hunt, crc to 0xffff, queue
// and output emptied, config registers to send_data 3, shutdown 1, startup 2.
// depends on cfdc_pkg, cfdc_front, cfdc_queue and cfdc_back
`default_nettype none

module command_frame_deframer_crc16_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // received byte channel
  input  wire logic                                 rx_valid,
  output logic                                      rx_ready,
  input  wire cfdc_pkg::in_word_t                   rx_word,
  // command result channel
  output logic                                      cmd_valid,
  input  wire logic                                 cmd_ready,
  output cfdc_pkg::out_word_t                       cmd_word,
  // configuration write port
  input  wire logic                                 cfg_we,
  input  wire logic [cfdc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [cfdc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  cfdc_pkg::cfg_regs_t cfg;
  cfdc_pkg::out_word_t push_word, q_head;
  logic                take, push, pop, q_full, q_nonempty;

  // a byte is taken whenever the queue has room for any result it may close
  assign rx_ready = !q_full;
  assign take     = rx_valid && rx_ready;

  // configuration registers; writes past the register list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.send_data_code <= cfdc_pkg::SEND_DATA_RESET;
      cfg.shutdown_code  <= cfdc_pkg::SHUTDOWN_RESET;
      cfg.startup_code   <= cfdc_pkg::STARTUP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cfdc_pkg::REG_SEND_DATA: cfg.send_data_code <= cfg_data;
        cfdc_pkg::REG_SHUTDOWN:  cfg.shutdown_code  <= cfg_data;
        cfdc_pkg::REG_STARTUP:   cfg.startup_code   <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: frame parsing and crc check
  cfdc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .word      (rx_word),
    .cfg       (cfg),
    .push      (push),
    .push_word (push_word)
  );

  // queue decouples the parser from output back-pressure
  cfdc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .full      (q_full),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  // back: registered result word
  cfdc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .pop        (pop),
    .out_valid  (cmd_valid),
    .out_ready  (cmd_ready),
    .out_word   (cmd_word)
  );

  // output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !cmd_valid)
    else $error("result valid right after reset");

  // a result is only ever one of the three command kinds
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> (cmd_word.command_kind == cfdc_pkg::KIND_SHUTDOWN ||
                   cmd_word.command_kind == cfdc_pkg::KIND_STARTUP ||
                   cmd_word.command_kind == cfdc_pkg::KIND_DATA))
    else $error("illegal command kind");

  // control commands carry an all-zero payload
  a_ctrl_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_word.command_kind != cfdc_pkg::KIND_DATA) |->
      (cmd_word.shunt_current_tenths == '0 && cmd_word.staleness == '0))
    else $error("control command with nonzero payload");

  // the parser never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("result pushed into full queue");

endmodule

`default_nettype wire
